@@ rtl/core/bet_pkg.sv @@
// Package for the breakpoint envelope table: constants, function codes, types.
package bet_pkg;
   localparam int MaxPoints = 64;
   localparam int IdxW      = $clog2(MaxPoints);
   localparam int CntW      = $clog2(MaxPoints + 1);
   localparam int EntryW    = 32 + 16 + 2;

   localparam logic [2:0] FUNC_ADD    = 3'd0;
   localparam logic [2:0] FUNC_REMOVE = 3'd1;
   localparam logic [2:0] FUNC_CLEAR  = 3'd2;
   localparam logic [2:0] FUNC_EVAL   = 3'd3;
   localparam logic [2:0] FUNC_READ   = 3'd4;

   localparam logic [1:0] CURVE_STEP   = 2'd0;
   localparam logic [1:0] CURVE_LINEAR = 2'd1;
   localparam logic [1:0] CURVE_SMOOTH = 2'd2;

   localparam logic CSR_MIN = 1'b0;
   localparam logic CSR_MAX = 1'b1;

   typedef struct packed {
      logic [31:0]       time_tick;
      logic signed [15:0] point_value;
      logic [1:0]        curve_kind;
   } entry_type;
endpackage

@@ rtl/core/breakpoint_envelope_table_unit.sv @@
// Top level of the breakpoint envelope table: sequencer around one table memory.
//
// Use: one request on req_* carries a command (add, remove, clear, evaluate,
// read point). Exactly one response leaves on rsp_* per request, in order.
// req_tdata (low to high): func[2:0], time_tick[34:3], point_value[50:35],
// curve_kind[52:51], entry_index[58:53], zero fill to 64 bits.
// rsp_tdata (low to high): result_value[15:0], result_time[47:16],
// result_curve[49:48], point_count[56:50], status[57], zero fill to 64 bits.
// One request is worked at a time. The table lives in one memory with a
// registered read, so every entry touched costs time: add and remove shift
// entries one at a time, each a read and then a write; evaluate reads the last
// entry, scans segments (a read and a check per entry) and then runs a 17-step
// serial divider plus three multiply stages; clear and read need no scan. The
// longest request is an evaluate that lands in the last segment of a full
// table.
// Reset clears the point count, state and output valid and sets the full signed
// 16-bit min/max range; table contents stay undefined and are never read beyond
// the count. When rsp_tready is low the response is held in the output register;
// one more request is taken and worked, and then waits until the output register frees.
// csr_* writes min_value (index 0) and max_value (index 1) on any clock edge with csr_wen high.
module breakpoint_envelope_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // func, time_tick, point_value, curve_kind, entry_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // result_value, result_time, result_curve, point_count, status
   input  logic        csr_wen,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bet_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_DISP  = 4'd1;
   localparam logic [3:0] ST_SHR   = 4'd2;  // add: read entry i-1
   localparam logic [3:0] ST_SHW   = 4'd3;  // add: compare and move
   localparam logic [3:0] ST_RMR   = 4'd4;  // remove: read entry i+1
   localparam logic [3:0] ST_RMW   = 4'd5;
   localparam logic [3:0] ST_RDR   = 4'd6;  // read point
   localparam logic [3:0] ST_EVR   = 4'd7;  // evaluate: read entry i
   localparam logic [3:0] ST_EVC   = 4'd8;  // evaluate: check entry i
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_MUL1  = 4'd10;
   localparam logic [3:0] ST_MUL2  = 4'd11;
   localparam logic [3:0] ST_MUL3  = 4'd12;
   localparam logic [3:0] ST_OUT   = 4'd13;
   localparam logic [3:0] ST_EVL   = 4'd14; // evaluate: check last entry

   // table memory
   entry_type mem [MaxPoints];
   entry_type rd_ff;
   logic              we;
   logic [IdxW-1:0]   waddr, raddr;
   entry_type         wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // control and working registers
   logic [3:0]        state_ff, state_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic signed [15:0] min_ff, max_ff;
   logic [2:0]        func_ff, func_in;
   logic [31:0]       tq_ff, tq_in;
   entry_type         new_ff, new_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic [CntW-1:0]   ptr_ff, ptr_in;
   entry_type         e0_ff, e0_in;
   logic              first_ff, first_in;
   logic [48:0]       rem_ff, rem_in;
   logic [31:0]       den_ff, den_in;
   logic [16:0]       q_ff, q_in;
   logic [5:0]        step_ff, step_in;
   logic [32:0]       p1_ff, p1_in;
   logic [16:0]       s_ff, s_in;
   logic signed [15:0] rval_ff, rval_in;
   logic [31:0]       rtime_ff, rtime_in;
   logic [1:0]        rcurve_ff, rcurve_in;
   logic              status_ff, status_in;
   logic              out_v_ff, out_v_in;
   logic [57:0]       out_data_ff, out_data_in;

   // request field split
   logic [2:0]        r_func;
   logic [31:0]       r_time;
   logic signed [15:0] r_val;
   logic [1:0]        r_curve;
   logic [IdxW-1:0]   r_idx;
   assign r_func  = req_tdata[2:0];
   assign r_time  = req_tdata[34:3];
   assign r_val   = req_tdata[50:35];
   assign r_curve = req_tdata[52:51];
   assign r_idx   = req_tdata[58:53];

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {6'd0, out_data_ff};

   logic signed [15:0] clamp_v;
   logic [48:0]        trial;
   logic signed [17:0] dv;
   logic signed [35:0] prod;
   logic [17:0]        three_m;
   logic [48:0]        smooth_prod;

   always_comb begin
      state_in = state_ff; count_in = count_ff; func_in = func_ff; tq_in = tq_ff;
      new_in = new_ff; idx_in = idx_ff; ptr_in = ptr_ff; e0_in = e0_ff;
      first_in = first_ff; rem_in = rem_ff; den_in = den_ff;
      q_in = q_ff; step_in = step_ff; p1_in = p1_ff; s_in = s_ff;
      rval_in = rval_ff; rtime_in = rtime_ff; rcurve_in = rcurve_ff;
      status_in = status_ff; out_v_in = out_v_ff; out_data_in = out_data_ff;
      we = 1'b0; waddr = '0; wdata = new_ff; raddr = '0;
      clamp_v = r_val; trial = '0; dv = '0; prod = '0; three_m = '0;
      smooth_prod = '0;

      if (out_v_ff && rsp_tready) out_v_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (r_val < min_ff) clamp_v = min_ff;
               else if (r_val > max_ff) clamp_v = max_ff;
               func_in = r_func; tq_in = r_time; idx_in = r_idx;
               new_in.time_tick = r_time; new_in.point_value = clamp_v;
               new_in.curve_kind = (r_curve == 2'd3) ? CURVE_SMOOTH : r_curve;
               rval_in = '0; rtime_in = '0; rcurve_in = '0; status_in = 1'b0;
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            case (func_ff)
               FUNC_ADD: begin
                  if (count_ff >= CntW'(MaxPoints)) begin
                     status_in = 1'b1; state_in = ST_OUT;
                  end else begin
                     ptr_in = count_ff; state_in = ST_SHR;
                  end
               end
               FUNC_REMOVE: begin
                  if ({1'b0, idx_ff} >= count_ff) begin
                     status_in = 1'b1; state_in = ST_OUT;
                  end else begin
                     ptr_in = {1'b0, idx_ff}; state_in = ST_RMR;
                  end
               end
               FUNC_CLEAR: begin
                  count_in = '0; state_in = ST_OUT;
               end
               FUNC_EVAL: begin
                  if (count_ff == '0) state_in = ST_OUT;
                  else state_in = ST_EVL;
               end
               FUNC_READ: begin
                  if ({1'b0, idx_ff} >= count_ff) begin
                     status_in = 1'b1; state_in = ST_OUT;
                  end else begin
                     state_in = ST_RDR;
                  end
               end
               default: begin
                  status_in = 1'b1; state_in = ST_OUT;
               end
            endcase
            raddr = (func_ff == FUNC_EVAL) ? IdxW'(count_ff - 1'b1) : idx_ff;
         end
         // insertion: walk down from the end, moving larger times up one slot
         ST_SHR: begin
            if (ptr_ff == '0) begin
               we = 1'b1; waddr = '0; wdata = new_ff;
               count_in = count_ff + 1'b1; state_in = ST_OUT;
            end else begin
               raddr = IdxW'(ptr_ff - 1'b1); state_in = ST_SHW;
            end
         end
         ST_SHW: begin
            we = 1'b1; waddr = ptr_ff[IdxW-1:0];
            if (rd_ff.time_tick > new_ff.time_tick) begin
               wdata = rd_ff; ptr_in = ptr_ff - 1'b1; state_in = ST_SHR;
            end else begin
               wdata = new_ff; count_in = count_ff + 1'b1; state_in = ST_OUT;
            end
         end
         // removal: pull later entries down one slot
         ST_RMR: begin
            if (ptr_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1; state_in = ST_OUT;
            end else begin
               raddr = IdxW'(ptr_ff + 1'b1); state_in = ST_RMW;
            end
         end
         ST_RMW: begin
            we = 1'b1; waddr = ptr_ff[IdxW-1:0]; wdata = rd_ff;
            ptr_in = ptr_ff + 1'b1; state_in = ST_RMR;
         end
         ST_RDR: begin
            rval_in = rd_ff.point_value; rtime_in = rd_ff.time_tick;
            rcurve_in = rd_ff.curve_kind; state_in = ST_OUT;
         end
         // at or after the last time: last value, else start the scan
         ST_EVL: begin
            if (tq_ff >= rd_ff.time_tick) begin
               rval_in = rd_ff.point_value; state_in = ST_OUT;
            end else begin
               ptr_in = '0; first_in = 1'b1; state_in = ST_EVR;
            end
         end
         // evaluation scan: e0 holds entry ptr-1, rd_ff holds entry ptr
         ST_EVR: begin
            raddr = ptr_ff[IdxW-1:0]; state_in = ST_EVC;
         end
         ST_EVC: begin
            if (first_ff) begin
               first_in = 1'b0;
               if (tq_ff <= rd_ff.time_tick || count_ff == CntW'(1)) begin
                  rval_in = rd_ff.point_value; state_in = ST_OUT;
               end else begin
                  e0_in = rd_ff; ptr_in = ptr_ff + 1'b1; state_in = ST_EVR;
               end
            end else if (tq_ff <= rd_ff.time_tick) begin
               // first segment containing the time (t0 < tq <= t1 here)
               e0_in = e0_ff;
               if (e0_ff.curve_kind == CURVE_STEP) begin
                  rval_in = e0_ff.point_value; state_in = ST_OUT;
               end else begin
                  new_in = rd_ff;
                  rem_in = {1'b0, tq_ff - e0_ff.time_tick, 16'd0};
                  den_in = rd_ff.time_tick - e0_ff.time_tick;
                  q_in = '0; step_in = 6'd17; state_in = ST_DIV;
               end
            end else if (ptr_ff + 1'b1 >= count_ff) begin
               rval_in = rd_ff.point_value; state_in = ST_OUT;
            end else begin
               e0_in = rd_ff; ptr_in = ptr_ff + 1'b1; state_in = ST_EVR;
            end
         end
         // restoring divide, one quotient bit per cycle (quotient fits 17 bits)
         ST_DIV: begin
            trial = rem_ff - ({17'd0, den_ff} << (step_ff - 1'b1));
            if (rem_ff >= ({17'd0, den_ff} << (step_ff - 1'b1))) begin
               rem_in = trial; q_in = q_ff | (17'd1 << (step_ff - 1'b1));
            end
            step_in = step_ff - 1'b1;
            if (step_ff == 6'd1) state_in = ST_MUL1;
         end
         ST_MUL1: begin
            p1_in = {16'd0, q_ff} * {16'd0, q_ff};
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (e0_ff.curve_kind == CURVE_SMOOTH) begin
               three_m = 18'd196608 - {q_ff, 1'b0};
               smooth_prod = p1_ff * three_m;
               s_in = smooth_prod[48:32];
            end else begin
               s_in = q_ff;
            end
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            dv = 18'(new_ff.point_value) - 18'(e0_ff.point_value);
            prod = dv * $signed({1'b0, s_ff});
            rval_in = 16'(18'(e0_ff.point_value) + 18'(prod >>> 16));
            state_in = ST_OUT;
         end
         // load the output register once it is free
         ST_OUT: begin
            if (!out_v_ff || rsp_tready) begin
               out_v_in = 1'b1; state_in = ST_IDLE;
               out_data_in = {status_ff, count_ff, rcurve_ff, rtime_ff, rval_ff};
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; count_ff <= '0; out_v_ff <= 1'b0;
         min_ff <= -16'sd32768; max_ff <= 16'sd32767; first_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; out_v_ff <= out_v_in;
         first_ff <= first_in;
         if (csr_wen && csr_index == CSR_MIN) min_ff <= csr_wdata;
         if (csr_wen && csr_index == CSR_MAX) max_ff <= csr_wdata;
      end
      func_ff <= func_in; tq_ff <= tq_in; new_ff <= new_in; idx_ff <= idx_in;
      ptr_ff <= ptr_in; e0_ff <= e0_in; rem_ff <= rem_in;
      den_ff <= den_in; q_ff <= q_in; step_ff <= step_in; p1_ff <= p1_in;
      s_ff <= s_in; rval_ff <= rval_in; rtime_ff <= rtime_in;
      rcurve_ff <= rcurve_in; status_ff <= status_in; out_data_ff <= out_data_in;
   end
endmodule
